/* design/aat_pkg.sv */
// aat_pkg: types, constants and helpers for the AABB affine transform block.
// Used by aat_row, aabb_affine_transform and aat_checker. No dependencies.
package aat_pkg;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int AXES      = 3;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int BOX_W     = 2 * AXES * COORD_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } reg_idx_t;

  localparam logic [REG_W-1:0] ROW0_COLS01_RST = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] ROW0_COLS23_RST = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] ROW1_COLS01_RST = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] ROW1_COLS23_RST = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] ROW2_COLS01_RST = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] ROW2_COLS23_RST = 64'h0001_0000_0000_0000;

  localparam logic signed [SUM_W-1:0] COORD_MAX_EXT =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_MIN_EXT =
    {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } aat_adv_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX_EXT) begin
      r = COORD_MAX_EXT[COORD_W-1:0];
    end else if (v < COORD_MIN_EXT) begin
      r = COORD_MIN_EXT[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/aat_row.sv */
// aat_row: one output axis. Four payload stages: products, per-term min/max,
// sums, then floor shift, translation and saturation. Uses aat_pkg.
module aat_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  aat_pkg::aat_adv_t                             adv,
  input  logic [aat_pkg::AXES-1:0][aat_pkg::COORD_W-1:0] lo_v,
  input  logic [aat_pkg::AXES-1:0][aat_pkg::COORD_W-1:0] hi_v,
  input  logic [aat_pkg::AXES-1:0][aat_pkg::COORD_W-1:0] coef,
  input  logic [aat_pkg::COORD_W-1:0]                   trans,
  output logic [aat_pkg::COORD_W-1:0]                   out_lo,
  output logic [aat_pkg::COORD_W-1:0]                   out_hi
);
  import aat_pkg::*;

  logic signed [PROD_W-1:0] p_lo [AXES];
  logic signed [PROD_W-1:0] p_hi [AXES];
  logic signed [PROD_W-1:0] t_min [AXES];
  logic signed [PROD_W-1:0] t_max [AXES];
  logic signed [SUM_W-1:0]  s_min;
  logic signed [SUM_W-1:0]  s_max;
  logic signed [SUM_W-1:0]  r_min;
  logic signed [SUM_W-1:0]  r_max;

  // The shift, translation and saturation are monotonic, so the extreme over
  // the eight corners is reached by picking each term's extreme on its own.
  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      if (adv.ld1) begin
        p_lo[k] <= $signed(coef[k]) * $signed(lo_v[k]);
        p_hi[k] <= $signed(coef[k]) * $signed(hi_v[k]);
      end
      if (adv.ld2) begin
        t_min[k] <= (p_lo[k] < p_hi[k]) ? p_lo[k] : p_hi[k];
        t_max[k] <= (p_lo[k] < p_hi[k]) ? p_hi[k] : p_lo[k];
      end
    end
    if (adv.ld3) begin
      s_min <= SUM_W'(t_min[0]) + SUM_W'(t_min[1]) + SUM_W'(t_min[2]);
      s_max <= SUM_W'(t_max[0]) + SUM_W'(t_max[1]) + SUM_W'(t_max[2]);
    end
    if (adv.ld4) begin
      out_lo <= sat_coord(r_min);
      out_hi <= sat_coord(r_max);
    end
  end

  always_comb begin
    r_min = (s_min >>> FRAC_BITS) + SUM_W'($signed(trans));
    r_max = (s_max >>> FRAC_BITS) + SUM_W'($signed(trans));
  end

endmodule

/* design/aabb_affine_transform.sv */
// aabb_affine_transform: bounding box of a box under a 3x4 affine matrix.
// Top level; holds the matrix registers and pipeline valids. Uses aat_pkg, aat_row.
//
//   channel    dir  handshake                      payload
//   s_axis     in   s_axis_tvalid/s_axis_tready    box lo/hi corners
//   m_axis     out  m_axis_tvalid/m_axis_tready    transformed box
//   cfg        in   cfg_we                         cfg_addr, cfg_wdata
//
// One item per cycle while m_axis is not stalled; the stages are multiply, term
// min/max, sum, and shift/translate/saturate.
// rst clears the stage valids and loads the identity matrix.
// Each stage loads when it is empty or the next one moves, so bubbles close
// up under a stall and nothing is lost or repeated.
module aabb_affine_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, 32 bits each
  input  logic [aat_pkg::BOX_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z, 32 bits each
  output logic [aat_pkg::BOX_W-1:0]       m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [aat_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [aat_pkg::REG_W-1:0]       cfg_wdata
);
  import aat_pkg::*;

  logic [REG_W-1:0] row_cols01 [AXES];
  logic [REG_W-1:0] row_cols23 [AXES];
  logic [3:0]       vld;
  aat_adv_t         adv;

  logic [AXES-1:0][COORD_W-1:0] lo_v;
  logic [AXES-1:0][COORD_W-1:0] hi_v;
  logic [AXES-1:0][COORD_W-1:0] res_lo;
  logic [AXES-1:0][COORD_W-1:0] res_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cols01[0] <= ROW0_COLS01_RST;
      row_cols23[0] <= ROW0_COLS23_RST;
      row_cols01[1] <= ROW1_COLS01_RST;
      row_cols23[1] <= ROW1_COLS23_RST;
      row_cols01[2] <= ROW2_COLS01_RST;
      row_cols23[2] <= ROW2_COLS23_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW0_COLS01: row_cols01[0] <= cfg_wdata;
        REG_ROW0_COLS23: row_cols23[0] <= cfg_wdata;
        REG_ROW1_COLS01: row_cols01[1] <= cfg_wdata;
        REG_ROW1_COLS23: row_cols23[1] <= cfg_wdata;
        REG_ROW2_COLS01: row_cols01[2] <= cfg_wdata;
        REG_ROW2_COLS23: row_cols23[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    adv.ld4 = !vld[3] || m_axis_tready;
    adv.ld3 = !vld[2] || adv.ld4;
    adv.ld2 = !vld[1] || adv.ld3;
    adv.ld1 = !vld[0] || adv.ld2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv.ld1) vld[0] <= s_axis_tvalid;
      if (adv.ld2) vld[1] <= vld[0];
      if (adv.ld3) vld[2] <= vld[1];
      if (adv.ld4) vld[3] <= vld[2];
    end
  end

  assign s_axis_tready = adv.ld1;
  assign m_axis_tvalid = vld[3];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      lo_v[a] = s_axis_tdata[a*COORD_W +: COORD_W];
      hi_v[a] = s_axis_tdata[(AXES+a)*COORD_W +: COORD_W];
      m_axis_tdata[a*COORD_W +: COORD_W]        = res_lo[a];
      m_axis_tdata[(AXES+a)*COORD_W +: COORD_W] = res_hi[a];
    end
  end

  for (genvar r = 0; r < AXES; r++) begin : g_row
    logic [AXES-1:0][COORD_W-1:0] coef;
    assign coef[0] = row_cols01[r][REG_W-1:COORD_W];
    assign coef[1] = row_cols01[r][COORD_W-1:0];
    assign coef[2] = row_cols23[r][REG_W-1:COORD_W];

    aat_row #(
      .FRAC_BITS(FRAC_BITS)
    ) u_row (
      .clk   (clk),
      .adv   (adv),
      .lo_v  (lo_v),
      .hi_v  (hi_v),
      .coef  (coef),
      .trans (row_cols23[r][COORD_W-1:0]),
      .out_lo(res_lo[r]),
      .out_hi(res_hi[r])
    );
  end

endmodule

/* design/aat_checker.sv */
// aat_checker: port-level checks on aabb_affine_transform, bound to the top level.
// Uses aat_pkg for port widths.
module aat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [aat_pkg::BOX_W-1:0]     m_axis_tdata
);
  import aat_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the pipeline can move");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("item did not reach the output in four cycles");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* tb/tb.sv */
// tb: stream testbench for aabb_affine_transform (box in, bounding box of its image out).
// Depends on aat_pkg and the block. Boxes are predicted in place and checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aat_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PHASES = 10;
  localparam int BOXES_PER_PHASE = 125;
  localparam logic [REG_IDX_W-1:0] REG_IDX_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_IDX_SPARE_HI = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [AXES-1:0] vec3_t;
  // lo in the low bits, x first: matches the tdata layout
  typedef struct packed {
    vec3_t hi;
    vec3_t lo;
  } box_t;
  typedef struct {
    box_t        box;
    int unsigned gap;
  } send_t;
  typedef enum {MIX_SMALL, MIX_FULL, MIX_EDGE} mix_t;

  localparam coord_t ONE = 32'sh0001_0000;
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam logic signed [67:0] ACC_CEIL = 68'sh0_7FFF_FFFF;
  localparam logic signed [67:0] ACC_FLOOR = -68'sh0_8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BOX_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [BOX_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  logic [REG_W-1:0] matrix_words [6];
  send_t boxes_to_send [$];
  box_t bounds_expected [$];
  int unsigned boxes_queued = 0;
  int unsigned boxes_sent = 0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b1;

  aabb_affine_transform #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t matrix_entry(int row, int col);
    logic [REG_W-1:0] w;
    w = matrix_words[row * 2 + col / 2];
    return (col % 2 == 1) ? w[31:0] : w[63:32];
  endfunction

  // One transformed coordinate: exact dot product, floor shift, translate, saturate.
  function automatic coord_t transform_axis(int row, vec3_t pt);
    logic signed [67:0] acc;
    logic signed [67:0] term;
    coord_t m;
    coord_t p;
    acc = '0;
    for (int k = 0; k < AXES; k++) begin
      m = matrix_entry(row, k);
      p = pt[k];
      term = m * p;
      acc = acc + term;
    end
    acc = (acc >>> FRAC) + matrix_entry(row, 3);
    if (acc > ACC_CEIL) return COORD_MAX;
    if (acc < ACC_FLOOR) return COORD_MIN;
    return acc[31:0];
  endfunction

  function automatic box_t transformed_bounds(box_t b);
    box_t r;
    vec3_t pt;
    coord_t t;
    r = '0;
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < AXES; a++) pt[a] = c[a] ? b.hi[a] : b.lo[a];
      for (int a = 0; a < AXES; a++) begin
        t = transform_axis(a, pt);
        if (c == 0 || $signed(t) < $signed(r.lo[a])) r.lo[a] = t;
        if (c == 0 || $signed(t) > $signed(r.hi[a])) r.hi[a] = t;
      end
    end
    return r;
  endfunction

  function automatic coord_t rand_value(mix_t kind, int unsigned span);
    coord_t v;
    case (kind)
      MIX_SMALL: v = $urandom_range(0, 2 * span) - span;
      MIX_FULL: v = $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0: v = COORD_MAX;
          1: v = COORD_MIN;
          2: v = '0;
          3: v = -1;
          4: v = 1;
          5: v = ONE;
          default: v = -ONE;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic box_t rand_box();
    box_t b;
    coord_t t;
    mix_t kind;
    for (int a = 0; a < AXES; a++) begin
      kind = ($urandom_range(0, 3) < 2) ? MIX_SMALL : mix_t'($urandom_range(1, 2));
      b.lo[a] = rand_value(kind, 32'h0400_0000);
      kind = ($urandom_range(0, 3) < 2) ? MIX_SMALL : mix_t'($urandom_range(1, 2));
      b.hi[a] = rand_value(kind, 32'h0400_0000);
    end
    // mostly well-formed boxes; the rest may keep min above max on some axes
    if ($urandom_range(0, 99) < 85) begin
      for (int a = 0; a < AXES; a++) begin
        if ($signed(b.lo[a]) > $signed(b.hi[a])) begin
          t = b.lo[a];
          b.lo[a] = b.hi[a];
          b.hi[a] = t;
        end
      end
    end
    return b;
  endfunction

  function automatic box_t mk_box(coord_t lx, coord_t ly, coord_t lz,
                                  coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.lo = {lz, ly, lx};
    b.hi = {hz, hy, hx};
    return b;
  endfunction

  task automatic enqueue_box(box_t b);
    send_t s;
    s.box = b;
    s.gap = quiet ? 0 : $urandom_range(0, 7);
    boxes_to_send.push_back(s);
    boxes_queued++;
  endtask

  task automatic send_directed();
    enqueue_box(mk_box(0, 0, 0, 0, 0, 0));
    enqueue_box(mk_box(ONE, ONE, ONE, ONE, ONE, ONE));
    enqueue_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    enqueue_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    enqueue_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    enqueue_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    enqueue_box(mk_box(-1, -1, -1, 1, 1, 1));
    enqueue_box(mk_box(-32'sh0001_8000, -32'sh0002_8000, -32'sh0003_8000,
                       32'sh0004_4000, 32'sh0000_8000, 32'sh0007_0000));
    enqueue_box(mk_box(32'sh0005_0000, -ONE, 0, -32'sh0005_0000, ONE, ONE));
    enqueue_box(mk_box(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                       32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA));
    enqueue_box(mk_box(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                       32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555));
    enqueue_box(mk_box(-ONE, -ONE, -ONE, 32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF));
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] addr, logic [REG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    if (addr <= REG_ROW2_COLS23) matrix_words[addr] = value;
  endtask

  task automatic load_matrix(mix_t kind, bit uniform, coord_t fill);
    reg_idx_t r;
    r = r.first();
    repeat (6) begin
      if (uniform) write_reg(r, {fill, fill});
      else write_reg(r, {rand_value(kind, 2 * ONE), rand_value(kind, 2 * ONE)});
      r = r.next();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (boxes_sent != boxes_queued || bounds_expected.size() != 0);
  endtask

  task automatic note_mismatch(string field, coord_t want, coord_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", field, want, got);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bounds_expected.push_back(transformed_bounds(s_axis_tdata));
        boxes_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item
      end else if (boxes_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (send_wait < boxes_to_send[0].gap) begin
        s_axis_tvalid <= 1'b0;
        send_wait <= send_wait + 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= boxes_to_send[0].box;
        send_wait <= 0;
        void'(boxes_to_send.pop_front());
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    box_t got;
    box_t want;
    int unsigned stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      stall = stall_left;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (bounds_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item on m_axis: %h", got);
        end else begin
          want = bounds_expected.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (got.lo[a] !== want.lo[a])
              note_mismatch($sformatf("out_lo[%0d]", a), want.lo[a], got.lo[a]);
            if (got.hi[a] !== want.hi[a])
              note_mismatch($sformatf("out_hi[%0d]", a), want.hi[a], got.hi[a]);
          end
        end
        stall = quiet ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    matrix_words[REG_ROW0_COLS01] = ROW0_COLS01_RST;
    matrix_words[REG_ROW0_COLS23] = ROW0_COLS23_RST;
    matrix_words[REG_ROW1_COLS01] = ROW1_COLS01_RST;
    matrix_words[REG_ROW1_COLS23] = ROW1_COLS23_RST;
    matrix_words[REG_ROW2_COLS01] = ROW2_COLS01_RST;
    matrix_words[REG_ROW2_COLS23] = ROW2_COLS23_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // identity matrix from reset, back to back
    quiet = 1'b1;
    send_directed();
    wait_drained();

    // all entries at the positive limit; writes past the last register are dropped
    write_reg(REG_IDX_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_IDX_SPARE_HI, {$urandom, $urandom});
    load_matrix(MIX_EDGE, 1'b1, COORD_MAX);
    quiet = 1'b0;
    send_directed();
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet = (ph % 3 == 0);
      if (ph == 0) load_matrix(MIX_EDGE, 1'b1, COORD_MIN);
      else if (ph == 1) load_matrix(MIX_EDGE, 1'b1, '0);
      else load_matrix(mix_t'(ph % 3), 1'b0, '0);
      repeat (BOXES_PER_PHASE) enqueue_box(rand_box());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
